// ===== design/bstt_pkg.sv =====
// Package for the best-score tie table: action codes, state enum, command/status structs.
// No dependencies.
package bstt_pkg;

    localparam int ID_W    = 10;
    localparam int SCORE_W = 16;
    localparam int ACT_W   = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSTALLED = 3'd0,
        ACT_REPLACED  = 3'd1,
        ACT_TIE_ADDED = 3'd2,
        ACT_TIE_DUP   = 3'd3,
        ACT_KEPT      = 3'd4,
        ACT_FULL      = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HDR_RD,
        ST_HDR_WAIT,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_INSTALL,
        ST_NEXT,
        ST_RD_WAIT,
        ST_RD_DONE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;      // clear one header entry after reset
        logic load;        // capture input item
        logic hdr_rd;      // read entry header
        logic use_tgt;     // second pass (target entry)
        logic decide;      // latch comparison
        logic tie_rd;      // read tie slot at idx
        logic idx_clr;     // idx <= 0
        logic idx_inc;     // idx <= idx + 1
        logic idx_load_n;  // idx <= count (shift start)
        logic idx_dec;     // idx <= idx - 1
        logic shift_wr;    // write slot idx with data read from idx-1
        logic ins_wr;      // write partner at idx, count+1
        logic inst_wr;     // write new header and list slot idx
        logic set_act;     // record action for current pass
        logic [ACT_W-1:0] act;
        logic read_rd;     // read-op tie slot fetch
        logic read_cap;    // capture read result
        logic out_load;    // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;    // clearing pass at last entry
        logic is_read;
        logic key_ok;      // key in range
        logic valid;       // entry valid
        logic cmp_lt;      // stored < incoming
        logic cmp_eq;
        logic idx_lt_n;    // idx < count
        logic tie_lt;      // stored tie < partner
        logic tie_eq;
        logic full;        // count >= max
        logic idx_gt_pos;  // idx > insert position
        logic idx_lt_len;  // idx + 1 < list length (install)
        logic out_busy;    // output register holds an item under out_stall
    } stat_t;

endpackage

// ===== design/bstt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module bstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/bstt_ctrl.sv =====
// Controller state machine of the best-score tie table.
// Depends on bstt_pkg.
module bstt_ctrl import bstt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t st,
    output cmd_t  cmd
);
    state_t state_reg, state_next;
    logic   pass_reg, pass_next;   // 0 query, 1 target

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        case (state_reg)
            ST_CLEAR:    state_next = st.clr_last ? ST_IDLE : ST_CLEAR;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pass_next  = 1'b0;
                    state_next = ST_HDR_RD;
                end
            end
            ST_HDR_RD:   state_next = ST_HDR_WAIT;
            ST_HDR_WAIT: state_next = st.is_read ? ST_RD_WAIT : ST_DECIDE;
            ST_DECIDE:
            begin
                if (!st.key_ok || (st.valid && !st.cmp_lt && !st.cmp_eq))
                    state_next = ST_NEXT;
                else if (!st.valid || st.cmp_lt)
                    state_next = ST_INSTALL;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:  state_next = st.idx_lt_n ? ST_SCAN_CHK : ST_SHIFT_RD;
            ST_SCAN_CHK:
            begin
                if (st.tie_lt)
                    state_next = ST_SCAN_RD;
                else if (st.tie_eq)
                    state_next = ST_NEXT;
                else
                    state_next = ST_SHIFT_RD;
            end
            ST_SHIFT_RD:
            begin
                if (st.full)
                    state_next = ST_NEXT;
                else if (st.idx_gt_pos)
                    state_next = ST_SHIFT_WR;
                else
                    state_next = ST_INSERT;
            end
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_INSERT:   state_next = ST_NEXT;
            ST_INSTALL:  state_next = st.idx_lt_len ? ST_INSTALL : ST_NEXT;
            ST_NEXT:
            begin
                if (!pass_reg)
                begin
                    pass_next  = 1'b1;
                    state_next = ST_HDR_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RD_WAIT:  state_next = ST_RD_DONE;
            ST_RD_DONE:  state_next = ST_OUT;
            ST_OUT:      state_next = st.out_busy ? ST_OUT : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.use_tgt = pass_reg;
        cmd.act     = ACT_KEPT;
        in_stall    = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_HDR_RD:
            begin
                cmd.hdr_rd  = 1'b1;
                cmd.idx_clr = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (!st.key_ok || (st.valid && !st.cmp_lt && !st.cmp_eq))
                begin
                    cmd.set_act = 1'b1;
                    cmd.act     = ACT_KEPT;
                end
                else if (!st.valid || st.cmp_lt)
                begin
                    cmd.set_act = 1'b1;
                    cmd.act     = st.valid ? ACT_REPLACED : ACT_INSTALLED;
                end
                else
                begin
                    cmd.tie_rd = 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                if (!st.idx_lt_n)
                begin
                    cmd.idx_load_n = 1'b1;
                end
            end
            ST_SCAN_CHK:
            begin
                if (st.tie_lt)
                begin
                    cmd.idx_inc = 1'b1;
                    cmd.tie_rd  = 1'b1;
                end
                else if (st.tie_eq)
                begin
                    cmd.set_act = 1'b1;
                    cmd.act     = ACT_TIE_DUP;
                end
                else
                begin
                    cmd.idx_load_n = 1'b1;
                end
            end
            ST_SHIFT_RD:
            begin
                if (st.full)
                begin
                    cmd.set_act = 1'b1;
                    cmd.act     = ACT_FULL;
                end
                else if (st.idx_gt_pos)
                begin
                    cmd.tie_rd = 1'b1;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_dec  = 1'b1;
            end
            ST_INSERT:
            begin
                cmd.ins_wr  = 1'b1;
                cmd.set_act = 1'b1;
                cmd.act     = ACT_TIE_ADDED;
            end
            ST_INSTALL:
            begin
                cmd.inst_wr = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            ST_HDR_WAIT:
            begin
                cmd.read_rd = st.is_read;
            end
            ST_RD_WAIT:
            begin
                cmd.read_rd = 1'b1;   // keep the slot address for the capture
            end
            ST_RD_DONE:
            begin
                cmd.read_cap = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = !st.out_busy;
            end
            default:
            begin
                cmd.act = ACT_KEPT;
            end
        endcase
    end
endmodule

// ===== design/bstt_dp.sv =====
// Datapath of the best-score tie table: input capture, entry header and tie memories,
// comparators, index counter, output register. Depends on bstt_pkg and bstt_ram.
module bstt_dp import bstt_pkg::*; #(
    parameter int NUM_KEYS = 1024,
    parameter int MAX_TIES = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     st,
    input  logic                      opcode,
    input  logic [ID_W-1:0]           query_id,
    input  logic [ID_W-1:0]           target_id,
    input  logic signed [SCORE_W-1:0] match_len,
    input  logic [SCORE_W-1:0]        ident_score,
    input  logic [SCORE_W-1:0]        query_len,
    input  logic [SCORE_W-1:0]        target_len,
    input  logic [2:0]                slot,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ACT_W-1:0]          query_action,
    output logic [ACT_W-1:0]          target_action,
    output logic                      entry_valid,
    output logic signed [SCORE_W-1:0] best_match_len,
    output logic [SCORE_W-1:0]        best_ident,
    output logic [SCORE_W-1:0]        best_read_len,
    output logic [3:0]                tie_count,
    output logic [ID_W-1:0]           tie_id
);
    localparam int KW  = $clog2(NUM_KEYS);
    localparam int TW  = $clog2(MAX_TIES);
    localparam int CW  = $clog2(MAX_TIES + 1);
    localparam int HW  = 1 + 3 * SCORE_W + CW;
    localparam int TAW = KW + TW;

    // captured item
    logic                      op_reg;
    logic [ID_W-1:0]           qid_reg, tid_reg;
    logic signed [SCORE_W-1:0] ml_reg;
    logic [SCORE_W-1:0]        id_reg, rl_reg;
    logic [ID_W-1:0]           l0_reg, l1_reg;
    logic                      len2_reg;
    logic [2:0]                slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            qid_reg  <= query_id;
            tid_reg  <= target_id;
            ml_reg   <= match_len;
            id_reg   <= ident_score;
            slot_reg <= slot;
            rl_reg   <= (query_len > target_len) ? query_len : target_len;
            len2_reg <= (query_len == target_len) && (query_id != target_id);
            if (query_len > target_len)
                l0_reg <= query_id;
            else if (query_len != target_len)
                l0_reg <= target_id;
            else
                l0_reg <= (query_id < target_id) ? query_id : target_id;
            l1_reg   <= (query_id < target_id) ? target_id : query_id;
        end
    end

    // current key
    logic [ID_W-1:0] key;
    logic            key_ok;
    logic [KW-1:0]   kaddr;
    assign key    = cmd.use_tgt ? tid_reg : qid_reg;
    assign key_ok = ({{(32-ID_W){1'b0}}, key} < NUM_KEYS);
    assign kaddr  = KW'(key);

    // clearing pass after reset: walks every header entry once
    logic [KW-1:0] clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_wr)
            clr_reg <= clr_reg + 1'b1;
    end

    // header memory: {valid, match_len, ident, read_len, count}
    logic                      hdr_we;
    logic [KW-1:0]             hdr_addr;
    logic [HW-1:0]             hdr_wdata, hdr_rdata;
    logic                      h_vld;
    logic signed [SCORE_W-1:0] h_ml;
    logic [SCORE_W-1:0]        h_id, h_rl;
    logic [CW-1:0]             h_cnt;
    logic                      entry_ok;
    assign {h_vld, h_ml, h_id, h_rl, h_cnt} = hdr_rdata;
    assign entry_ok = h_vld && key_ok;

    // latched header count for the current pass, and the score comparison
    logic [CW-1:0] cnt_reg;
    logic          lt_cmp;

    // tie memory
    logic            tie_we;
    logic [TAW-1:0]  tie_addr;
    logic [ID_W-1:0] tie_wdata, tie_rdata;
    logic [TW:0]     idx_reg;
    logic [TW:0]     pos_reg;
    logic [ID_W-1:0] hold_reg;
    logic [ID_W-1:0] partner;
    logic [TW-1:0]   rd_idx;
    logic            inst_list_lt;

    assign partner = (!len2_reg || (l0_reg != key)) ? l0_reg : l1_reg;

    always_comb
    begin
        rd_idx = idx_reg[TW-1:0];
        if (cmd.tie_rd && (cmd.idx_inc))
            rd_idx = TW'(idx_reg + 1'b1);
        else if (cmd.tie_rd && !cmd.decide && !cmd.idx_inc)
            rd_idx = TW'(idx_reg - 1'b1);   // shift: fetch slot below
        else if (cmd.read_rd)
            rd_idx = TW'(slot_reg);
        else if (cmd.decide)
            rd_idx = '0;
    end

    always_comb
    begin
        tie_we    = 1'b0;
        tie_wdata = hold_reg;
        if (cmd.shift_wr)
        begin
            tie_we    = 1'b1;
            tie_wdata = tie_rdata;
        end
        else if (cmd.ins_wr)
        begin
            tie_we    = 1'b1;
            tie_wdata = partner;
        end
        else if (cmd.inst_wr)
        begin
            tie_we    = 1'b1;
            tie_wdata = (idx_reg == '0) ? l0_reg : l1_reg;
        end
    end
    assign tie_addr = (tie_we) ? {kaddr, idx_reg[TW-1:0]} : {kaddr, rd_idx};

    assign hdr_addr  = cmd.clr_wr ? clr_reg : kaddr;
    assign hdr_we    = cmd.clr_wr || cmd.ins_wr || (cmd.inst_wr && idx_reg == '0);
    assign hdr_wdata = cmd.clr_wr ? '0
        : cmd.ins_wr ? {1'b1, h_ml, h_id, h_rl, CW'(cnt_reg + 1'b1)}
        : {1'b1, ml_reg, id_reg, rl_reg, CW'(len2_reg ? 2 : 1)};

    bstt_ram #(.WIDTH(HW), .DEPTH(NUM_KEYS)) u_hdr (
        .clk   (clk),
        .we    (hdr_we),
        .addr  (hdr_addr),
        .wdata (hdr_wdata),
        .rdata (hdr_rdata)
    );

    bstt_ram #(.WIDTH(ID_W), .DEPTH(NUM_KEYS * MAX_TIES)) u_tie (
        .clk   (clk),
        .we    (tie_we),
        .addr  (tie_addr),
        .wdata (tie_wdata),
        .rdata (tie_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
            cnt_reg <= h_cnt;
        if (cmd.idx_load_n)
        begin
            pos_reg <= idx_reg;
            idx_reg <= (TW+1)'(cnt_reg);
        end
        else if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - 1'b1;
        hold_reg <= tie_rdata;
    end

    always_comb
    begin
        if (h_ml != ml_reg)
            lt_cmp = h_ml < ml_reg;
        else if (h_id != id_reg)
            lt_cmp = h_id < id_reg;
        else
            lt_cmp = h_rl < rl_reg;
    end

    assign inst_list_lt = (idx_reg == '0) && len2_reg;

    assign st.clr_last   = (clr_reg == KW'(NUM_KEYS - 1));
    assign st.is_read    = op_reg;
    assign st.key_ok     = key_ok;
    assign st.valid      = entry_ok;
    assign st.cmp_lt     = lt_cmp;
    assign st.cmp_eq     = (h_ml == ml_reg) && (h_id == id_reg) && (h_rl == rl_reg);
    assign st.idx_lt_n   = ({1'b0, idx_reg} < (TW+2)'(cnt_reg));
    assign st.tie_lt     = tie_rdata < partner;
    assign st.tie_eq     = tie_rdata == partner;
    assign st.full       = ({1'b0, cnt_reg} >= (CW+1)'(MAX_TIES));
    assign st.idx_gt_pos = idx_reg > pos_reg;
    assign st.idx_lt_len = inst_list_lt;

    // per-pass actions and read results
    logic [ACT_W-1:0]          qa_reg, ta_reg;
    logic                      rv_reg;
    logic signed [SCORE_W-1:0] rml_reg;
    logic [SCORE_W-1:0]        rid_reg, rrl_reg;
    logic [3:0]                rcnt_reg;
    logic [ID_W-1:0]           rtie_reg;
    logic [CW-1:0]             rdcnt;
    assign rdcnt = h_cnt;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qa_reg   <= ACT_KEPT;
            ta_reg   <= ACT_KEPT;
            rv_reg   <= 1'b0;
            rml_reg  <= '0;
            rid_reg  <= '0;
            rrl_reg  <= '0;
            rcnt_reg <= '0;
            rtie_reg <= '0;
        end
        if (cmd.set_act)
        begin
            if (cmd.use_tgt)
                ta_reg <= cmd.act;
            else
                qa_reg <= cmd.act;
        end
        if (cmd.read_cap && entry_ok)
        begin
            rv_reg   <= 1'b1;
            rml_reg  <= h_ml;
            rid_reg  <= h_id;
            rrl_reg  <= h_rl;
            rcnt_reg <= 4'(rdcnt);
            rtie_reg <= ({29'd0, slot_reg} < 32'(rdcnt)
                         && {29'd0, slot_reg} < MAX_TIES) ? tie_rdata : '0;
        end
    end

    // output register
    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            query_action   <= qa_reg;
            target_action  <= ta_reg;
            entry_valid    <= rv_reg;
            best_match_len <= rml_reg;
            best_ident     <= rid_reg;
            best_read_len  <= rrl_reg;
            tie_count      <= rcnt_reg;
            tie_id         <= rtie_reg;
        end
    end
    assign out_valid   = ov_reg;
    assign st.out_busy = ov_reg && out_stall;
endmodule

// ===== design/best_score_tie_table_core.sv =====
// Top level of the best-score tie table: controller plus datapath.
// Depends on bstt_pkg, bstt_ctrl, bstt_dp, bstt_ram.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid/in_stall    opcode..slot
//  out      from block out_valid/out_stall  query_action..tie_id
//
// One item at a time. A read fetches the entry header and the addressed tie
// slot and captures them for the result. An update runs two entry passes, each
// a header read and compare, then an install of one or two slots, or a sorted
// scan of the tie slots (each slot read, then checked, through the single
// tie-memory port) and a shift-insert.
// After reset a clearing pass over all NUM_KEYS entries zeroes the header memory
// (valid bits included) with in_stall high. The output register holds a result
// under out_stall and the block waits for it to drain before loading the next result.
module best_score_tie_table_core import bstt_pkg::*; #(
    parameter int NUM_KEYS = 1024,
    parameter int MAX_TIES = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [ID_W-1:0]           query_id,
    input  logic [ID_W-1:0]           target_id,
    input  logic signed [SCORE_W-1:0] match_len,
    input  logic [SCORE_W-1:0]        ident_score,
    input  logic [SCORE_W-1:0]        query_len,
    input  logic [SCORE_W-1:0]        target_len,
    input  logic [2:0]                slot,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ACT_W-1:0]          query_action,
    output logic [ACT_W-1:0]          target_action,
    output logic                      entry_valid,
    output logic signed [SCORE_W-1:0] best_match_len,
    output logic [SCORE_W-1:0]        best_ident,
    output logic [SCORE_W-1:0]        best_read_len,
    output logic [3:0]                tie_count,
    output logic [ID_W-1:0]           tie_id
);
    cmd_t  cmd;
    stat_t st;

    bstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bstt_dp #(.NUM_KEYS(NUM_KEYS), .MAX_TIES(MAX_TIES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .opcode         (opcode),
        .query_id       (query_id),
        .target_id      (target_id),
        .match_len      (match_len),
        .ident_score    (ident_score),
        .query_len      (query_len),
        .target_len     (target_len),
        .slot           (slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .query_action   (query_action),
        .target_action  (target_action),
        .entry_valid    (entry_valid),
        .best_match_len (best_match_len),
        .best_ident     (best_ident),
        .best_read_len  (best_read_len),
        .tie_count      (tie_count),
        .tie_id         (tie_id)
    );
endmodule

// ===== design/bstt_checker.sv =====
// Port-level checker for the best-score tie table, bound to the top level.
// Depends on bstt_pkg.
module bstt_checker import bstt_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ACT_W-1:0] query_action,
    input logic [ACT_W-1:0] target_action,
    input logic             entry_valid
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(query_action))
        else $error("result dropped under stall");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    a_read_actions: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_valid |-> query_action == ACT_KEPT && target_action == ACT_KEPT)
        else $error("read result carries update action");

    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> query_action <= ACT_FULL && target_action <= ACT_FULL)
        else $error("action code out of range");
endmodule

bind best_score_tie_table_core bstt_checker u_bstt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .query_action  (query_action),
    .target_action (target_action),
    .entry_valid   (entry_valid)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for best_score_tie_table_core.
// Uses bstt_pkg for widths and action codes; holds its own copy of the score table.
module tb;
    import bstt_pkg::*;

    localparam int KEYS       = 1024;
    localparam int TIES       = 8;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 80;

    // Result fields of one item, as predicted
    typedef struct {
        action_t              qa;
        action_t              ta;
        logic                 ev;
        logic signed [15:0]   bml;
        logic [15:0]          bid;
        logic [15:0]          brl;
        logic [3:0]           tc;
        logic [ID_W-1:0]      tid;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = 1'b0;
    logic [ID_W-1:0] query_id = '0;
    logic [ID_W-1:0] target_id = '0;
    logic signed [15:0] match_len = '0;
    logic [15:0] ident_score = '0;
    logic [15:0] query_len = '0;
    logic [15:0] target_len = '0;
    logic [2:0] slot = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ACT_W-1:0] query_action;
    logic [ACT_W-1:0] target_action;
    logic entry_valid;
    logic signed [15:0] best_match_len;
    logic [15:0] best_ident;
    logic [15:0] best_read_len;
    logic [3:0] tie_count;
    logic [ID_W-1:0] tie_id;

    // Shadow of the table
    logic               tbl_valid [KEYS];
    logic signed [15:0] tbl_ml    [KEYS];
    logic [15:0]        tbl_ident [KEYS];
    logic [15:0]        tbl_rlen  [KEYS];
    int                 tbl_count [KEYS];
    logic [ID_W-1:0]    tbl_ties  [KEYS][TIES];

    result_t pending_results[$];
    int      err_count = 0;
    int      cycle_count = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      ties_full_seen = 0;
    bit      quiet_input = 1'b0;   // no gaps on the sender side
    bit      quiet_output = 1'b0;  // no stalls on the receiver side
    int      hold_request = 0;     // long receiver hold-off, in cycles
    int      hold_left = 0;

    best_score_tie_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .query_id(query_id), .target_id(target_id),
        .match_len(match_len), .ident_score(ident_score),
        .query_len(query_len), .target_len(target_len), .slot(slot),
        .out_valid(out_valid), .out_stall(out_stall),
        .query_action(query_action), .target_action(target_action),
        .entry_valid(entry_valid), .best_match_len(best_match_len),
        .best_ident(best_ident), .best_read_len(best_read_len),
        .tie_count(tie_count), .tie_id(tie_id)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Pick a gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_request - 1;
            hold_request <= 0;
        end
        else if (quiet_output)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 9) < 7)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 9) < 8)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    // Comparison of stored score against incoming: -1 less, 0 equal, 1 greater
    function automatic int score_order(int key, logic signed [15:0] ml,
                                       logic [15:0] idn, logic [15:0] rl);
        if (tbl_ml[key] != ml)
            return (tbl_ml[key] < ml) ? -1 : 1;
        if (tbl_ident[key] != idn)
            return (tbl_ident[key] < idn) ? -1 : 1;
        if (tbl_rlen[key] != rl)
            return (tbl_rlen[key] < rl) ? -1 : 1;
        return 0;
    endfunction

    function automatic action_t add_partner(int key, logic [ID_W-1:0] partner);
        int n;
        int pos;
        n = tbl_count[key];
        pos = 0;
        while (pos < n && tbl_ties[key][pos] < partner)
            pos++;
        if (pos < n && tbl_ties[key][pos] == partner)
            return ACT_TIE_DUP;
        if (n >= TIES)
            return ACT_FULL;
        for (int j = n; j > pos; j--)
            tbl_ties[key][j] = tbl_ties[key][j-1];
        tbl_ties[key][pos] = partner;
        tbl_count[key] = n + 1;
        return ACT_TIE_ADDED;
    endfunction

    function automatic action_t merge_score(int key, logic signed [15:0] ml,
                                            logic [15:0] idn, logic [15:0] rl,
                                            logic [ID_W-1:0] p0, logic [ID_W-1:0] p1,
                                            int plen);
        int c;
        bit was_valid;
        was_valid = tbl_valid[key];
        c = was_valid ? score_order(key, ml, idn, rl) : -1;
        if (c < 0)
        begin
            tbl_valid[key] = 1'b1;
            tbl_ml[key] = ml;
            tbl_ident[key] = idn;
            tbl_rlen[key] = rl;
            tbl_count[key] = plen;
            tbl_ties[key][0] = p0;
            if (plen == 2)
                tbl_ties[key][1] = p1;
            return was_valid ? ACT_REPLACED : ACT_INSTALLED;
        end
        if (c > 0)
            return ACT_KEPT;
        // equal score: the partner other than this key
        if (plen == 1 || p0 != key)
            return add_partner(key, p0);
        return add_partner(key, p1);
    endfunction

    // Expected result of one item; updates the shadow table
    function automatic result_t table_result(logic op, logic [ID_W-1:0] qid,
                                             logic [ID_W-1:0] tid,
                                             logic signed [15:0] ml, logic [15:0] idn,
                                             logic [15:0] ql, logic [15:0] tl,
                                             logic [2:0] sl);
        result_t r;
        logic [ID_W-1:0] p0;
        logic [ID_W-1:0] p1;
        logic [15:0] rl;
        int plen;
        r = '{ACT_KEPT, ACT_KEPT, 1'b0, '0, '0, '0, '0, '0};
        p1 = '0;
        if (op == 1'b0)
        begin
            plen = 1;
            if (ql > tl)
            begin
                rl = ql;
                p0 = qid;
            end
            else
            begin
                rl = tl;
                if (ql != tl)
                    p0 = tid;
                else if (qid == tid)
                    p0 = qid;
                else
                begin
                    p0 = (qid < tid) ? qid : tid;
                    p1 = (qid < tid) ? tid : qid;
                    plen = 2;
                end
            end
            r.qa = merge_score(qid, ml, idn, rl, p0, p1, plen);
            r.ta = merge_score(tid, ml, idn, rl, p0, p1, plen);
        end
        else if (tbl_valid[qid])
        begin
            r.ev = 1'b1;
            r.bml = tbl_ml[qid];
            r.bid = tbl_ident[qid];
            r.brl = tbl_rlen[qid];
            r.tc = 4'(tbl_count[qid]);
            if (sl < tbl_count[qid])
                r.tid = tbl_ties[qid][sl];
        end
        return r;
    endfunction

    // Offer one item, wait for acceptance, then optionally idle
    task automatic send_item(logic op, logic [ID_W-1:0] qid, logic [ID_W-1:0] tid,
                             logic signed [15:0] ml, logic [15:0] idn,
                             logic [15:0] ql, logic [15:0] tl, logic [2:0] sl);
        int gap;
        in_valid <= 1'b1;
        opcode <= op;
        query_id <= qid;
        target_id <= tid;
        match_len <= ml;
        ident_score <= idn;
        query_len <= ql;
        target_len <= tl;
        slot <= sl;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(),
                               table_result(op, qid, tid, ml, idn, ql, tl, sl));
        items_sent++;
        gap = quiet_input ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic read_entry(logic [ID_W-1:0] key, logic [2:0] sl);
        send_item(1'b1, key, ID_W'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), sl);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (query_action == ACT_FULL || target_action == ACT_FULL)
                ties_full_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                err_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (query_action != e.qa)
                begin
                    $display("%0t: query_action exp %0d got %0d", $time, e.qa, query_action);
                    err_count++;
                end
                if (target_action != e.ta)
                begin
                    $display("%0t: target_action exp %0d got %0d", $time, e.ta,
                             target_action);
                    err_count++;
                end
                if (entry_valid !== e.ev)
                begin
                    $display("%0t: entry_valid exp %0d got %0d", $time, e.ev, entry_valid);
                    err_count++;
                end
                if (best_match_len !== e.bml)
                begin
                    $display("%0t: best_match_len exp %0d got %0d", $time, e.bml,
                             best_match_len);
                    err_count++;
                end
                if (best_ident !== e.bid)
                begin
                    $display("%0t: best_ident exp %0d got %0d", $time, e.bid, best_ident);
                    err_count++;
                end
                if (best_read_len !== e.brl)
                begin
                    $display("%0t: best_read_len exp %0d got %0d", $time, e.brl,
                             best_read_len);
                    err_count++;
                end
                if (tie_count !== e.tc)
                begin
                    $display("%0t: tie_count exp %0d got %0d", $time, e.tc, tie_count);
                    err_count++;
                end
                if (tie_id !== e.tid)
                begin
                    $display("%0t: tie_id exp %0d got %0d", $time, e.tid, tie_id);
                    err_count++;
                end
            end
        end
    end

    // Field extremes, equal lengths, same-key pair, invalid read
    task automatic test_extremes();
        send_item(1'b0, 10'd1, 10'd2, -16'sd32768, 16'd0, 16'd0, 16'd0, 3'd0);
        send_item(1'b0, 10'd1, 10'd2, -16'sd32768, 16'd0, 16'd0, 16'd0, 3'd0);
        send_item(1'b0, 10'd1, 10'd3, 16'sd32767, 16'hFFFF, 16'hFFFF, 16'd0, 3'd0);
        send_item(1'b0, 10'd5, 10'd5, 16'sd0, 16'd7, 16'd9, 16'd9, 3'd0);
        send_item(1'b0, 10'd5, 10'd5, 16'sd0, 16'd7, 16'd9, 16'd9, 3'd0);
        read_entry(10'd1, 3'd0);
        read_entry(10'd1, 3'd7);
        read_entry(10'd2, 3'd1);
        read_entry(10'd5, 3'd0);
        read_entry(10'd1023, 3'd7);
    endtask

    // Fill one tie list out of order, overflow it, then lose a score compare
    task automatic test_tie_list();
        for (int p = 29; p >= 20; p--)
            send_item(1'b0, 10'd10, p[ID_W-1:0], 16'sd100, 16'd50, 16'd4, 16'd8, 3'd0);
        send_item(1'b0, 10'd10, 10'd22, 16'sd100, 16'd50, 16'd4, 16'd8, 3'd0);
        send_item(1'b0, 10'd10, 10'd40, 16'sd100, 16'd49, 16'd4, 16'd8, 3'd0);
        for (int s = 0; s < TIES; s++)
            read_entry(10'd10, s[2:0]);
    endtask

    // Receiver holds off long while the sender keeps offering items
    task automatic test_backpressure();
        quiet_input = 1'b1;
        hold_request = 400;
        for (int i = 0; i < 20; i++)
            send_item(1'b0, ID_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 7)),
                      16'sd3, 16'd3, 16'($urandom_range(0, 2)),
                      16'($urandom_range(0, 2)), 3'd0);
        quiet_input = 1'b0;
    endtask

    // Mostly well-formed pairs over a small key pool with few distinct scores
    task automatic test_random(int count);
        logic [ID_W-1:0] q;
        logic [ID_W-1:0] t;
        for (int i = 0; i < count; i++)
        begin
            // alternate stretches with and without idling
            quiet_input = ((i / 150) % 4 == 1);
            quiet_output = ((i / 150) % 4 == 2);
            q = ($urandom_range(0, 9) < 9) ? ID_W'($urandom_range(0, 31))
                                           : ID_W'($urandom());
            t = ($urandom_range(0, 9) < 9) ? ID_W'($urandom_range(0, 31))
                                           : ID_W'($urandom());
            if ($urandom_range(0, 99) < 12)
                send_item(1'($urandom()), ID_W'($urandom()), ID_W'($urandom()),
                          16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 3'($urandom()));
            else if ($urandom_range(0, 99) < 30)
                read_entry(q, 3'($urandom()));
            else
                send_item(1'b0, q, t, $signed(16'($urandom_range(0, 2)) - 16'd1),
                          16'($urandom_range(0, 1)), 16'($urandom_range(0, 2)),
                          16'($urandom_range(0, 2)), 3'($urandom()));
        end
        quiet_input = 1'b0;
        quiet_output = 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k < KEYS; k++)
        begin
            tbl_valid[k] = 1'b0;
            tbl_count[k] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_tie_list();
        test_backpressure();
        test_random(1800);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Ran %0d items (updates and reads), %0d results checked, %0d with a full",
                 items_sent, results_seen, ties_full_seen);
        $display("tie list; included a %0d-cycle receiver hold-off.", 400);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
